// ===== design/utem_pkg.sv =====
package utem_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharT     = 8'h54;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharZ     = 8'h5A;

   localparam logic [2:0] YearDigits = 3'd4;
   localparam logic [2:0] FracDigits = 3'd3;
   localparam logic [2:0] TwoDigits  = 3'd2;

   localparam logic [13:0] EpochYear   = 14'd1970;
   localparam logic [21:0] EpochOffset = 22'd477;
   localparam logic [13:0] DivHundred  = 14'd5243;
   localparam int          DivShift    = 19;
   localparam logic [26:0] DayMillis   = 27'd86400000;
   localparam logic [26:0] HourMillis  = 27'd3600000;
   localparam logic [26:0] MinMillis   = 27'd60000;
   localparam logic [26:0] SecMillis   = 27'd1000;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [47:0] epoch_millis;
   } rsp_type;

   typedef struct packed {
      logic        form_ok;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  millis;
   } fields_type;

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] days;
      case (month)
         4'd1: days = 9'd0;
         4'd2: days = 9'd31;
         4'd3: days = 9'd59;
         4'd4: days = 9'd90;
         4'd5: days = 9'd120;
         4'd6: days = 9'd151;
         4'd7: days = 9'd181;
         4'd8: days = 9'd212;
         4'd9: days = 9'd243;
         4'd10: days = 9'd273;
         4'd11: days = 9'd304;
         4'd12: days = 9'd334;
         default: days = 9'd0;
      endcase
      if (leap && month > 4'd2) begin
         days = days + 9'd1;
      end
      return days;
   endfunction

endpackage

// ===== design/utem_parser.sv =====
module utem_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  utem_pkg::req_type   req_word,
   output logic                push,
   output utem_pkg::fields_type rec
);
   import utem_pkg::*;

   typedef enum logic [2:0] {
      PhYear, PhMonth, PhDay, PhHour, PhMinute, PhSecond, PhFrac
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [13:0] acc_ff, acc_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [9:0]  millis_ff, millis_in;
   logic        zone_ff, zone_in;
   logic        bad_ff, bad_in;

   logic [7:0] c;
   logic       is_digit;
   logic [2:0] max_digits;
   logic       sep_ok;

   assign c = req_word.char_code;
   assign is_digit = (c >= CharZero) && (c <= CharNine);

   always_comb begin
      unique case (phase_ff)
         PhYear: begin
            max_digits = YearDigits;
            sep_ok = (c == CharDash);
         end
         PhMonth: begin
            max_digits = TwoDigits;
            sep_ok = (c == CharDash);
         end
         PhDay: begin
            max_digits = TwoDigits;
            sep_ok = (c == CharT);
         end
         PhHour, PhMinute: begin
            max_digits = TwoDigits;
            sep_ok = (c == CharColon);
         end
         PhSecond: begin
            max_digits = TwoDigits;
            sep_ok = (c == CharDot) || (c == CharZ);
         end
         PhFrac: begin
            max_digits = FracDigits;
            sep_ok = (c == CharZ);
         end
         default: begin
            max_digits = TwoDigits;
            sep_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      year_in = year_ff;
      month_in = month_ff;
      day_in = day_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      millis_in = millis_ff;
      zone_in = zone_ff;
      bad_in = bad_ff;
      if (take && !bad_ff && !zone_ff) begin
         if (is_digit) begin
            if (count_ff >= max_digits) begin
               bad_in = 1'b1;
            end else begin
               acc_in = 14'(acc_ff * 14'd10) + 14'(c[3:0]);
               count_in = count_ff + 3'd1;
            end
         end else if (count_ff == 3'd0 || !sep_ok) begin
            bad_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PhYear: year_in = acc_ff;
               PhMonth: month_in = acc_ff[6:0];
               PhDay: day_in = acc_ff[6:0];
               PhHour: hour_in = acc_ff[6:0];
               PhMinute: minute_in = acc_ff[6:0];
               PhSecond: second_in = acc_ff[6:0];
               PhFrac: millis_in = acc_ff[9:0];
               default: bad_in = 1'b1;
            endcase
            acc_in = '0;
            count_in = '0;
            if (c == CharZ) begin
               zone_in = 1'b1;
            end else begin
               phase_in = phase_type'(phase_ff + 3'd1);
            end
         end
      end
   end

   assign push = take && req_word.is_last;

   always_comb begin
      rec.form_ok = zone_in && !bad_in;
      rec.year = year_in;
      rec.month = month_in;
      rec.day = day_in;
      rec.hour = hour_in;
      rec.minute = minute_in;
      rec.second = second_in;
      rec.millis = millis_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff <= PhYear;
         count_ff <= '0;
         acc_ff <= '0;
         year_ff <= '0;
         month_ff <= '0;
         day_ff <= '0;
         hour_ff <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         millis_ff <= '0;
         zone_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         acc_ff <= acc_in;
         year_ff <= year_in;
         month_ff <= month_in;
         day_ff <= day_in;
         hour_ff <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         millis_ff <= millis_in;
         zone_ff <= zone_in;
         bad_ff <= bad_in;
      end
   end

endmodule

// ===== design/utem_fifo.sv =====
module utem_fifo #(
   parameter int Depth = utem_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  utem_pkg::fields_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output utem_pkg::fields_type head_data
);
   import utem_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   fields_type            mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full = (cnt_ff == CntWidth'(Depth));
   assign head_valid = (cnt_ff != '0);
   assign head_data = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/utem_convert.sv =====
module utem_convert (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  utem_pkg::fields_type in_rec,
   output logic                 in_take,
   output logic                 rsp_valid,
   output utem_pkg::rsp_type    rsp_word,
   input  logic                 rsp_stall
);
   import utem_pkg::*;

   // stage 1: year - 1 and its reciprocal product
   logic        v1_ff;
   fields_type  rec1_ff;
   logic [13:0] p1_ff;
   logic [26:0] prod1_ff;

   // stage 2: checks, leap year, day counts
   logic        v2_ff;
   logic        ok2_ff;
   logic [21:0] ydays2_ff;
   logic [8:0]  doy2_ff;
   logic [6:0]  hour2_ff, minute2_ff, second2_ff;
   logic [9:0]  millis2_ff;

   // stage 3: total days and time of day
   logic        v3_ff;
   logic        ok3_ff;
   logic [21:0] days3_ff;
   logic [26:0] tod3_ff;

   // output register
   logic        v4_ff;
   rsp_type     rsp_ff;

   logic r1, r2, r3, r4;

   logic [13:0] p_in;
   logic [7:0]  q;
   logic [6:0]  r;
   logic        leap;
   logic [4:0]  mlen;
   logic        ok_in;
   logic [21:0] ydays_in;
   logic [8:0]  doy_in;
   logic [26:0] tod_in;
   logic [48:0] day_ms;

   assign r4 = !v4_ff || !rsp_stall;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_take = in_valid && r1;

   assign p_in = in_rec.year - 14'd1;

   always_comb begin
      q = prod1_ff[DivShift +: 8];
      r = 7'(p1_ff - 14'(q * 8'd100));
      leap = (p1_ff[1:0] == 2'd3) && ((r != 7'd99) || (q[1:0] == 2'd3));
      mlen = month_length(rec1_ff.month[3:0], leap);
      ok_in = rec1_ff.form_ok
         && (rec1_ff.year >= EpochYear)
         && (rec1_ff.month >= 7'd1) && (rec1_ff.month <= 7'd12)
         && (rec1_ff.day >= 7'd1) && (rec1_ff.day <= 7'(mlen))
         && (rec1_ff.hour <= 7'd23)
         && (rec1_ff.minute <= 7'd59)
         && (rec1_ff.second <= 7'd60);
      ydays_in = 22'(rec1_ff.year - EpochYear) * 22'd365
         + 22'(p1_ff[13:2]) - 22'(q) + 22'(q[7:2]) - EpochOffset;
      doy_in = days_before(rec1_ff.month[3:0], leap) + 9'(rec1_ff.day) - 9'd1;
   end

   assign tod_in = 27'(hour2_ff) * HourMillis + 27'(minute2_ff) * MinMillis
      + 27'(second2_ff) * SecMillis + 27'(millis2_ff);

   assign day_ms = 49'(days3_ff) * 49'(DayMillis);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
         if (r4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         rec1_ff <= in_rec;
         p1_ff <= p_in;
         prod1_ff <= 27'(p_in) * 27'(DivHundred);
      end
      if (r2) begin
         ok2_ff <= ok_in;
         ydays2_ff <= ydays_in;
         doy2_ff <= doy_in;
         hour2_ff <= rec1_ff.hour;
         minute2_ff <= rec1_ff.minute;
         second2_ff <= rec1_ff.second;
         millis2_ff <= rec1_ff.millis;
      end
      if (r3) begin
         ok3_ff <= ok2_ff;
         days3_ff <= ydays2_ff + 22'(doy2_ff);
         tod3_ff <= tod_in;
      end
      if (r4) begin
         rsp_ff.valid_res <= ok3_ff;
         rsp_ff.epoch_millis <= ok3_ff ? (day_ms[47:0] + 48'(tod3_ff)) : '0;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_word = rsp_ff;

endmodule

// ===== design/utc_timestamp_to_epoch_ms.sv =====
// channel  ports                           direction  word
// req      req_valid req_stall req_word    in         one character, last flag
// rsp      rsp_valid rsp_stall rsp_word    out        valid flag, epoch milliseconds
//
// one character a cycle while req_stall is low
// the 4-stage back end pipeline takes one string a cycle unless rsp_stall holds it
// reset clears the parser, queue and pipeline valids; no clearing pass
// req_stall rises only while the queue between parser and back end is full
module utc_timestamp_to_epoch_ms #(
   parameter int QueueDepth = utem_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  utem_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output utem_pkg::rsp_type rsp_word
);
   import utem_pkg::*;

   logic       take;
   logic       push;
   logic       full;
   fields_type rec;
   logic       head_valid;
   fields_type head_rec;
   logic       pop;

   assign req_stall = full;
   assign take = req_valid && !full;

   utem_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_word (req_word),
      .push     (push),
      .rec      (rec)
   );

   utem_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (rec),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_rec)
   );

   utem_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_rec    (head_rec),
      .in_take   (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

endmodule
